/* hw/rtl/kfm_pkg.sv */
// shared constants, types and codes of the kmp first-match search core
package kfm_pkg;

  // pattern capacity and the widths that follow from it
  localparam int PATTERN_MAX = 128;
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

  // fixed field widths
  localparam int SYM_W  = 8;
  localparam int POS_W  = 32;
  localparam int CFG_W  = 8;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 2;

  localparam logic [POS_W-1:0]  POS_MAX             = '1;
  localparam logic [ADDR_W-1:0] ADDR_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_W-1:0]  PATTERN_LENGTH_RST  = 8'd1;

  // item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_NONE     = 2'd0,
    STATUS_MATCH    = 2'd1,
    STATUS_NO_MATCH = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } kfm_status_e;

  // write of one pattern entry into the cell row
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] fail;
  } kfm_wr_t;

endpackage

/* hw/rtl/kmp_first_match_search_core.sv */
// top level of the kmp first-match search core: control, config port and cell row
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+--------------------------------------
//   in       | input     | in_valid_i / in_stall_o  | cmd_i, symbol_i, first_i, last_of_text_i
//   out      | output    | out_valid_o / out_stall_i| status_o, end_position_o
//   config   | input     | psel / penable / pready  | paddr, pwdata, prdata
//
// one item walks the cell row at a time: it is taken while the sequencer is idle, then
// the walk sequencer probes the cell row and follows f failure links in all, where f
// is 0 for overflow, the first pattern byte and bytes after a match, and at most the
// matched length otherwise
// the result sits in an output register while the next item walks; a stalled result
// holds that walk at its end, and the input stalls until the walk is done
// reset clears the control state; pattern cells are undefined until loaded
module kmp_first_match_search_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cmd_i,
  input  logic [kfm_pkg::SYM_W-1:0]  symbol_i,
  input  logic                       first_i,
  input  logic                       last_of_text_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [kfm_pkg::POS_W-1:0]  end_position_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kfm_pkg::ADDR_W-1:0] paddr,
  input  logic [kfm_pkg::DATA_W-1:0] pwdata,
  output logic [kfm_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  localparam int IDX_W = kfm_pkg::IDX_W;
  localparam int LEN_W = kfm_pkg::LEN_W;

  // control and item registers
  state_e                      state_q, state_d;
  logic                        is_text_q, is_text_d;
  logic                        quick_q, quick_d;     // result known without a walk
  logic                        ovf_q, ovf_d;
  logic                        last_q, last_d;
  logic [kfm_pkg::SYM_W-1:0]   sym_q, sym_d;
  logic [IDX_W-1:0]            k_q, k_d;             // load slot
  logic [IDX_W-1:0]            s_q, s_d;             // current probe index
  logic [LEN_W-1:0]            len_q, len_d;
  logic [kfm_pkg::POS_W-1:0]   pos_q, pos_d;

  // search state
  logic [LEN_W-1:0]            load_count_q, load_count_d;
  logic [IDX_W-1:0]            load_prefix_q, load_prefix_d;
  logic [IDX_W-1:0]            matched_q, matched_d;
  logic [kfm_pkg::POS_W-1:0]   text_pos_q, text_pos_d;
  logic                        found_q, found_d;
  logic [kfm_pkg::CFG_W-1:0]   pattern_length_q, pattern_length_d;

  // result register
  logic                        out_valid_q, out_valid_d;
  kfm_pkg::kfm_status_e        status_q, status_d;
  logic [kfm_pkg::POS_W-1:0]   end_pos_q, end_pos_d;

  // cell row
  kfm_pkg::kfm_wr_t                           wr;
  logic [kfm_pkg::PATTERN_MAX-1:0]            eq_vec;
  logic [kfm_pkg::PATTERN_MAX-1:0][IDX_W-1:0] link_vec;

  kfm_cell_row u_row (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .sym_i  (sym_q),
    .eq_o   (eq_vec),
    .link_o (link_vec)
  );

  // handshakes
  logic in_acc;
  logic out_free;
  logic cfg_wr;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cfg_wr     = psel && penable && pwrite && pready;

  assign pready  = 1'b1;
  assign prdata  = kfm_pkg::DATA_W'(pattern_length_q);

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign end_position_o = end_pos_q;

  // pattern length in use: zero acts as one, capped at the cell count
  logic [LEN_W-1:0] used_len;

  always_comb begin
    if (pattern_length_q == '0) begin
      used_len = LEN_W'(1);
    end else if (32'(pattern_length_q) > 32'(kfm_pkg::PATTERN_MAX)) begin
      used_len = LEN_W'(kfm_pkg::PATTERN_MAX);
    end else begin
      used_len = LEN_W'(pattern_length_q);
    end
  end

  // walk step: probe cell s, extend on a hit, stop at the bottom of the link chain
  logic             hit;
  logic             stop;
  logic [LEN_W-1:0] adv;

  assign hit  = eq_vec[s_q];
  assign stop = quick_q || hit || (s_q == '0);
  assign adv  = hit ? (LEN_W'(s_q) + LEN_W'(1)) : '0;

  // item entry values
  logic [LEN_W-1:0]          cnt_in;
  logic [IDX_W-1:0]          pre_in;
  logic [kfm_pkg::POS_W-1:0] tp_in;
  logic [IDX_W-1:0]          m_in;
  logic                      found_in;

  always_comb begin
    cnt_in   = first_i ? '0 : load_count_q;
    pre_in   = first_i ? '0 : load_prefix_q;
    tp_in    = first_i ? '0 : text_pos_q;
    m_in     = first_i ? '0 : matched_q;
    found_in = first_i ? 1'b0 : found_q;
  end

  always_comb begin
    state_d          = state_q;
    is_text_d        = is_text_q;
    quick_d          = quick_q;
    ovf_d            = ovf_q;
    last_d           = last_q;
    sym_d            = sym_q;
    k_d              = k_q;
    s_d              = s_q;
    len_d            = len_q;
    pos_d            = pos_q;
    load_count_d     = load_count_q;
    load_prefix_d    = load_prefix_q;
    matched_d        = matched_q;
    text_pos_d       = text_pos_q;
    found_d          = found_q;
    pattern_length_d = pattern_length_q;
    out_valid_d      = out_valid_q;
    status_d         = status_q;
    end_pos_d        = end_pos_q;

    wr      = '0;
    wr.idx  = k_q;
    wr.sym  = sym_q;
    wr.fail = quick_q ? '0 : IDX_W'(adv);

    if (cfg_wr && (paddr == kfm_pkg::ADDR_PATTERN_LENGTH)) begin
      pattern_length_d = pwdata[kfm_pkg::CFG_W-1:0];
    end

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d   = S_WALK;
          sym_d     = symbol_i;
          last_d    = last_of_text_i;
          is_text_d = (cmd_i == kfm_pkg::CMD_TEXT);
          len_d     = used_len;
          ovf_d     = 1'b0;
          if (cmd_i == kfm_pkg::CMD_LOAD) begin
            load_count_d  = cnt_in;
            load_prefix_d = pre_in;
            ovf_d         = (32'(cnt_in) >= 32'(kfm_pkg::PATTERN_MAX));
            quick_d       = ovf_d || (cnt_in == '0);
            k_d           = IDX_W'(cnt_in);
            s_d           = (LEN_W'(pre_in) >= cnt_in) ? '0 : pre_in;
            pos_d         = '0;
          end else begin
            found_d    = found_in;
            pos_d      = tp_in;
            text_pos_d = (tp_in == kfm_pkg::POS_MAX) ? tp_in : tp_in + 1'b1;
            quick_d    = found_in;
            // a lowered length restarts the match
            s_d        = (LEN_W'(m_in) >= used_len) ? '0 : m_in;
            matched_d  = m_in;
          end
        end
      end

      S_WALK: begin
        if (!stop) begin
          s_d = link_vec[s_q];
        end else if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          end_pos_d   = pos_q;
          status_d    = kfm_pkg::STATUS_NONE;
          if (!is_text_q) begin
            if (ovf_q) begin
              status_d = kfm_pkg::STATUS_OVERFLOW;
            end else begin
              wr.en         = 1'b1;
              load_prefix_d = wr.fail;
              load_count_d  = LEN_W'(k_q) + LEN_W'(1);
            end
          end else if (!quick_q) begin
            if (adv >= len_q) begin
              status_d  = kfm_pkg::STATUS_MATCH;
              found_d   = 1'b1;
              matched_d = '0;
            end else begin
              matched_d = IDX_W'(adv);
              if (last_q) begin
                status_d = kfm_pkg::STATUS_NO_MATCH;
              end
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      is_text_q        <= 1'b0;
      quick_q          <= 1'b0;
      ovf_q            <= 1'b0;
      last_q           <= 1'b0;
      sym_q            <= '0;
      k_q              <= '0;
      s_q              <= '0;
      len_q            <= '0;
      pos_q            <= '0;
      load_count_q     <= '0;
      load_prefix_q    <= '0;
      matched_q        <= '0;
      text_pos_q       <= '0;
      found_q          <= 1'b0;
      pattern_length_q <= kfm_pkg::PATTERN_LENGTH_RST;
      out_valid_q      <= 1'b0;
      status_q         <= kfm_pkg::STATUS_NONE;
      end_pos_q        <= '0;
    end else begin
      state_q          <= state_d;
      is_text_q        <= is_text_d;
      quick_q          <= quick_d;
      ovf_q            <= ovf_d;
      last_q           <= last_d;
      sym_q            <= sym_d;
      k_q              <= k_d;
      s_q              <= s_d;
      len_q            <= len_d;
      pos_q            <= pos_d;
      load_count_q     <= load_count_d;
      load_prefix_q    <= load_prefix_d;
      matched_q        <= matched_d;
      text_pos_q       <= text_pos_d;
      found_q          <= found_d;
      pattern_length_q <= pattern_length_d;
      out_valid_q      <= out_valid_d;
      status_q         <= status_d;
      end_pos_q        <= end_pos_d;
    end
  end

endmodule

/* hw/rtl/kfm_cell.sv */
// one pattern cell: holds a pattern byte and its failure value
module kfm_cell (
  input  logic                      clk_i,
  input  logic [kfm_pkg::IDX_W-1:0] cell_idx_i,
  input  kfm_pkg::kfm_wr_t          wr_i,
  input  logic [kfm_pkg::SYM_W-1:0] sym_i,
  input  logic [kfm_pkg::IDX_W-1:0] prev_fail_i,
  output logic [kfm_pkg::IDX_W-1:0] fail_o,
  output logic                      eq_o,
  output logic [kfm_pkg::IDX_W-1:0] link_o
);

  logic [kfm_pkg::SYM_W-1:0] pat_q;
  logic [kfm_pkg::IDX_W-1:0] fail_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == cell_idx_i)) begin
      pat_q  <= wr_i.sym;
      fail_q <= wr_i.fail;
    end
  end

  assign fail_o = fail_q;
  assign eq_o   = (pat_q == sym_i);
  // fall back to the left neighbor's border, never forward
  assign link_o = (prev_fail_i < cell_idx_i) ? prev_fail_i : '0;

endmodule

/* hw/rtl/kfm_cell_row.sv */
// row of pattern cells, each passing its failure value to the next
module kfm_cell_row (
  input  logic                                              clk_i,
  input  kfm_pkg::kfm_wr_t                                  wr_i,
  input  logic [kfm_pkg::SYM_W-1:0]                         sym_i,
  output logic [kfm_pkg::PATTERN_MAX-1:0]                   eq_o,
  output logic [kfm_pkg::PATTERN_MAX-1:0][kfm_pkg::IDX_W-1:0] link_o
);

  logic [kfm_pkg::PATTERN_MAX-1:0][kfm_pkg::IDX_W-1:0] fail;

  for (genvar i = 0; i < kfm_pkg::PATTERN_MAX; i++) begin : g_cell
    logic [kfm_pkg::IDX_W-1:0] prev_fail;

    if (i == 0) begin : g_head
      assign prev_fail = '0;
    end else begin : g_body
      assign prev_fail = fail[i-1];
    end

    kfm_cell u_cell (
      .clk_i       (clk_i),
      .cell_idx_i  (kfm_pkg::IDX_W'(i)),
      .wr_i        (wr_i),
      .sym_i       (sym_i),
      .prev_fail_i (prev_fail),
      .fail_o      (fail[i]),
      .eq_o        (eq_o[i]),
      .link_o      (link_o[i])
    );
  end

endmodule

/* test/tb.sv */
// self-checking testbench of the kmp first-match search core
`timescale 1ns / 1ps

module tb;
  import kfm_pkg::*;

  localparam int ITEMS       = 1450;  // stimulus stops once this many items went in
  localparam int IDLE_LIMIT  = 3000;  // cycles with no item moving before the watchdog fires
  localparam int HOLD_AT     = 300;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES = 400;   // length of that hold-off
  localparam int DIR_N       = 25;

  // one result item as the block should report it
  typedef struct packed {
    kfm_status_e      status;
    logic [POS_W-1:0] pos;
  } kfm_res_t;

  // one row of the directed table; cfg is written (block idle) before the row when set_cfg
  typedef struct packed {
    bit               set_cfg;
    logic [CFG_W-1:0] cfg;
    logic             cmd;
    logic [SYM_W-1:0] sym;
    logic             is_first;
    logic             is_last;
    bit               typed;
    kfm_status_e      st;
    logic [POS_W-1:0] pos;
  } dir_row_t;

  logic              clk_i;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall_o;
  logic              cmd;
  logic [SYM_W-1:0]  symbol;
  logic              is_first;
  logic              is_last;
  logic              out_valid_o;
  logic              out_stall;
  logic [1:0]        status_o;
  logic [POS_W-1:0]  end_position_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  kmp_first_match_search_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd),
    .symbol_i       (symbol),
    .first_i        (is_first),
    .last_of_text_i (is_last),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .status_o       (status_o),
    .end_position_o (end_position_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // search predictor: its own copy of the pattern cells, failure links and
  // match state, stepped once per accepted item
  // ---------------------------------------------------------------------------
  logic [SYM_W-1:0] pat_mem [PATTERN_MAX];
  int               fail_mem [PATTERN_MAX];
  int               ld_cnt;
  int               ld_border;
  int               match_len;
  logic [POS_W-1:0] txt_pos;
  bit               found;
  logic [CFG_W-1:0] cfg_len;

  kfm_res_t report_q [$];   // expected result items, oldest first

  // length actually used for matching: 0 acts as 1, above capacity acts as capacity
  function automatic int eff_len(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > PATTERN_MAX) return PATTERN_MAX;
    return int'(v);
  endfunction

  // follow failure links until sym extends the border, then step over sym if it does
  function automatic int border_walk(int len, logic [SYM_W-1:0] sym);
    int back;
    while (len > 0 && sym != pat_mem[len]) begin
      back = fail_mem[len-1];
      len  = (back < len) ? back : 0;
    end
    if (sym == pat_mem[len]) len++;
    return len;
  endfunction

  function automatic kfm_res_t kmp_predict(logic c, logic [SYM_W-1:0] sym, logic f, logic l);
    kfm_res_t r;
    int       k;
    int       t;
    int       len;
    int       s;
    r.status = STATUS_NONE;
    r.pos    = '0;
    if (c == CMD_LOAD) begin
      if (f) begin
        ld_cnt    = 0;
        ld_border = 0;
      end
      if (ld_cnt >= PATTERN_MAX) begin
        r.status = STATUS_OVERFLOW;
      end else begin
        k = ld_cnt;
        pat_mem[k] = sym;
        if (k == 0) begin
          fail_mem[0] = 0;
          ld_border   = 0;
        end else begin
          t = ld_border;
          if (t >= k) t = 0;
          t = border_walk(t, sym);
          if (t > k) t = 0;
          fail_mem[k] = t;
          ld_border   = t;
        end
        ld_cnt = k + 1;
      end
    end else begin
      len = eff_len(cfg_len);
      if (f) begin
        txt_pos   = '0;
        match_len = 0;
        found     = 1'b0;
      end
      r.pos = txt_pos;
      if (txt_pos != POS_MAX) txt_pos++;
      if (!found) begin
        s = match_len;
        if (s >= len) s = 0;   // length was lowered under a running match
        s = border_walk(s, sym);
        if (s >= len) begin
          r.status = STATUS_MATCH;
          found    = 1'b1;
          s        = 0;
        end else if (l) begin
          r.status = STATUS_NO_MATCH;
        end
        match_len = s;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  int items_sent;
  int wr_max;       // highest pattern entry count ever loaded; text never reads past it
  int cfg_writes;
  int err_cnt;
  bit snd_calm;     // no gaps between items in this phase

  // one item: optional gap, offer it, hold it until taken, then predict
  task automatic issue(logic c, logic [SYM_W-1:0] sym, logic f, logic l,
                       bit typed = 1'b0, kfm_res_t want = '0);
    int       gap;
    kfm_res_t r;
    gap = snd_calm ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd      = c;
    symbol   = sym;
    is_first = f;
    is_last  = l;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = kmp_predict(c, sym, f, l);
    if (typed) r = want;
    report_q.push_back(r);
    if (ld_cnt > wr_max) wr_max = ld_cnt;
    items_sent++;
  endtask

  // stop offering and wait for every expected result to come back
  task automatic drain_reports();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (report_q.size() != 0) @(negedge clk_i);
  endtask

  // apb write of pattern_length, then a read back of the same register
  task automatic set_pattern_length(logic [CFG_W-1:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = ADDR_PATTERN_LENGTH;
    pwdata  = DATA_W'(val);
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_len = val;
    cfg_writes++;
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DATA_W'(val)) begin
      $error("prdata: expected %0d, actual %0d", val, prdata);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // directed table: after reset (length 1), match on the last byte, fall back
  // through failure links, bytes after the last without first, length lowered
  // mid-text, length 0, and a load in the middle of a text
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [DIR_N];

  initial begin
    dir_rows = '{
      // pattern 00 ff 00, searched with the reset length of 1
      '{1'b0, 8'd0, CMD_LOAD, 8'h00, 1'b1, 1'b0, 1'b1, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_LOAD, 8'hff, 1'b0, 1'b1, 1'b1, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_LOAD, 8'h00, 1'b0, 1'b0, 1'b1, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_TEXT, 8'hff, 1'b1, 1'b1, 1'b1, STATUS_NO_MATCH, 32'd0},
      '{1'b0, 8'd0, CMD_TEXT, 8'h00, 1'b1, 1'b0, 1'b1, STATUS_MATCH,    32'd0},
      // text already matched: its last byte reports nothing
      '{1'b0, 8'd0, CMD_TEXT, 8'h00, 1'b0, 1'b1, 1'b1, STATUS_NONE,     32'd1},
      // full length 3, match lands on the last byte
      '{1'b1, 8'd3, CMD_TEXT, 8'h00, 1'b1, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_TEXT, 8'hff, 1'b0, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_TEXT, 8'h00, 1'b0, 1'b1, 1'b0, STATUS_NONE,     32'd0},
      // 00 00 ff 00: mismatch on the second byte falls back one link
      '{1'b0, 8'd0, CMD_TEXT, 8'h00, 1'b1, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_TEXT, 8'hff, 1'b0, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_TEXT, 8'h00, 1'b0, 1'b1, 1'b0, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_TEXT, 8'hff, 1'b1, 1'b1, 1'b1, STATUS_NO_MATCH, 32'd0},
      // continue past the last byte with no first flag
      '{1'b0, 8'd0, CMD_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_TEXT, 8'hff, 1'b0, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      // two bytes matched, then the length drops to 2 under them
      '{1'b0, 8'd0, CMD_TEXT, 8'h00, 1'b1, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_TEXT, 8'hff, 1'b0, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      '{1'b1, 8'd2, CMD_TEXT, 8'h55, 1'b0, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      // length 0 acts as 1
      '{1'b1, 8'd0, CMD_TEXT, 8'h00, 1'b1, 1'b1, 1'b1, STATUS_MATCH,    32'd0},
      // a pattern byte appended in the middle of a text keeps the match state
      '{1'b1, 8'd3, CMD_TEXT, 8'h00, 1'b1, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_LOAD, 8'haa, 1'b0, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_TEXT, 8'hff, 1'b0, 1'b0, 1'b0, STATUS_NONE,     32'd0},
      '{1'b0, 8'd0, CMD_TEXT, 8'h00, 1'b0, 1'b1, 1'b0, STATUS_NONE,     32'd0}
    };
  end

  // ---------------------------------------------------------------------------
  // receiver side: draws a hold-off per result, with calm stretches and one
  // long hold-off that fills the block and stalls its input
  // ---------------------------------------------------------------------------
  int rcv_cnt;
  int rcv_seen;
  int rcv_wait;
  bit rcv_calm;
  bit hold_done;
  int status_tally [4];
  kfm_res_t got_exp;

  always @(negedge clk_i) begin
    if (rcv_seen != rcv_cnt) begin
      rcv_seen = rcv_cnt;
      if (rcv_cnt % 64 == 0) rcv_calm = ($urandom_range(0, 3) == 0);
      rcv_wait = rcv_calm ? 0 : $urandom_range(0, 16);
      if (!hold_done && rcv_cnt >= HOLD_AT) begin
        rcv_wait  = HOLD_CYCLES;
        hold_done = 1'b1;
      end
    end
    if (rcv_wait > 0) begin
      out_stall = 1'b1;
      rcv_wait--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && !out_stall) begin
      if (report_q.size() == 0) begin
        $error("result with no item waiting: status %0d end_position %0d",
               status_o, end_position_o);
        err_cnt++;
      end else begin
        got_exp = report_q.pop_front();
        if (status_o !== got_exp.status) begin
          $error("status: expected %0d, actual %0d", got_exp.status, status_o);
          err_cnt++;
        end
        if (end_position_o !== got_exp.pos) begin
          $error("end_position: expected %0d, actual %0d", got_exp.pos, end_position_o);
          err_cnt++;
        end
      end
      status_tally[status_o]++;
      rcv_cnt++;
    end
  end

  // watchdog: counts cycles in which no item moves on either channel
  int idle_cnt;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence: reset, directed table, then random phases
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int               i;
    int               j;
    int               t;
    int               r;
    int               phase;
    int               asz;
    int               pat_len;
    int               extra;
    int               ul;
    int               nt;
    int               tl;
    int               ins;
    bit               append;
    bit               reuse;
    bit               cont;
    bit               has_last;
    logic [CFG_W-1:0] c;
    logic [SYM_W-1:0] alph [3];
    logic [SYM_W-1:0] pat [136];
    logic [SYM_W-1:0] txt [160];
    kfm_res_t         want;

    // every input known from time zero
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    cmd       = CMD_LOAD;
    symbol    = '0;
    is_first  = 1'b0;
    is_last   = 1'b0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;

    // predictor state after reset
    for (i = 0; i < PATTERN_MAX; i++) begin
      pat_mem[i]  = '0;
      fail_mem[i] = 0;
    end
    ld_cnt    = 0;
    ld_border = 0;
    match_len = 0;
    txt_pos   = '0;
    found     = 1'b0;
    cfg_len   = PATTERN_LENGTH_RST;

    items_sent = 0;
    wr_max     = 0;
    cfg_writes = 0;
    err_cnt    = 0;
    snd_calm   = 1'b0;
    rcv_cnt    = 0;
    rcv_seen   = 0;
    rcv_wait   = 0;
    rcv_calm   = 1'b0;
    hold_done  = 1'b0;
    idle_cnt   = 0;
    for (i = 0; i < 4; i++) status_tally[i] = 0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // directed part
    for (i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].set_cfg) begin
        drain_reports();
        set_pattern_length(dir_rows[i].cfg);
      end
      want.status = dir_rows[i].st;
      want.pos    = dir_rows[i].pos;
      issue(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].is_first, dir_rows[i].is_last,
            dir_rows[i].typed, want);
    end

    // random phases: load a pattern over a small alphabet, set a length, then
    // stream texts that often hold the pattern, with noise items mixed in;
    // phase 2 loads past capacity (overflow), phases 2 and 3 use lengths 128 and 255
    phase   = 0;
    pat_len = 1;
    asz     = 1;
    for (j = 0; j < 3; j++) alph[j] = '0;
    for (j = 0; j < 136; j++) pat[j] = '0;
    while (items_sent < ITEMS) begin
      phase++;
      snd_calm = ($urandom_range(0, 3) == 0);
      reuse    = (phase > 3) && ($urandom_range(0, 4) == 0);
      if (!reuse) begin
        asz = $urandom_range(1, 3);
        for (j = 0; j < 3; j++) alph[j] = SYM_W'($urandom_range(0, 255));
        r = $urandom_range(0, 15);
        if (phase == 2 || r == 0) pat_len = PATTERN_MAX;
        else if (r < 4) pat_len = $urandom_range(9, 40);
        else pat_len = $urandom_range(1, 8);
        extra  = (pat_len == PATTERN_MAX) ? $urandom_range(1, 3) : 0;
        append = (phase != 2) && (ld_cnt + pat_len <= PATTERN_MAX) &&
                 ($urandom_range(0, 7) == 0);
        for (j = 0; j < 136; j++) pat[j] = alph[$urandom_range(0, asz - 1)];
        for (j = 0; j < pat_len + extra; j++)
          issue(CMD_LOAD, pat[j], (j == 0) && !append, 1'($urandom_range(0, 1)));
      end

      drain_reports();
      r = $urandom_range(0, 9);
      if (phase == 2) c = CFG_W'(PATTERN_MAX);
      else if (phase == 3) c = 8'd255;
      else if (r == 0) c = 8'd0;
      else if (r == 1) c = CFG_W'($urandom_range(1, wr_max));
      else if (r == 2 && wr_max == PATTERN_MAX)
        c = CFG_W'($urandom_range(PATTERN_MAX + 1, 255));
      else c = CFG_W'(pat_len);
      set_pattern_length(c);
      ul = eff_len(c);   // never above wr_max, so text reads only loaded entries

      nt = $urandom_range(1, 4);
      for (t = 0; t < nt && items_sent < ITEMS; t++) begin
        tl = $urandom_range(1, 30);
        if (tl < ul + 2 && $urandom_range(0, 2) != 0) tl = ul + $urandom_range(0, 8);
        for (j = 0; j < tl; j++) txt[j] = alph[$urandom_range(0, asz - 1)];
        if (tl >= ul && $urandom_range(0, 2) != 0) begin
          ins = $urandom_range(0, tl - ul);
          for (j = 0; j < ul; j++) txt[ins + j] = pat[j];
        end
        // sometimes carry on the previous text, sometimes leave it open-ended
        cont     = ($urandom_range(0, 7) == 0);
        has_last = ($urandom_range(0, 7) != 0);
        for (j = 0; j < tl && items_sent < ITEMS; j++) begin
          if ($urandom_range(0, 11) == 0)
            issue(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          issue(CMD_TEXT, txt[j], (j == 0) && !cont, (j == tl - 1) && has_last);
        end
      end
    end

    drain_reports();
    repeat (10) @(posedge clk_i);

    $display("run: %0d items (%0d directed) over %0d phases, %0d results, %0d length writes",
             items_sent, DIR_N, phase, rcv_cnt, cfg_writes);
    $display("seen: %0d matches, %0d texts without match, %0d overflows, %0d plain, %0d errors",
             status_tally[STATUS_MATCH], status_tally[STATUS_NO_MATCH],
             status_tally[STATUS_OVERFLOW], status_tally[STATUS_NONE], err_cnt);
    if (err_cnt == 0 && report_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* kmp_first_match_search_core.f */
hw/rtl/kfm_pkg.sv
hw/rtl/kfm_cell.sv
hw/rtl/kfm_cell_row.sv
hw/rtl/kmp_first_match_search_core.sv
test/tb.sv
